@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, clocked on i_clk, reset by i_rst_n in the using scope
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/tpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tpt_pkg
// types and constants shared by the task priority table
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int TASK_ID_W     = 10;
    localparam int USER_W        = 20;
    localparam int PRIO_W        = 32;
    localparam int NUM_TASKS_DEF = 1024;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_EDIT = 2'd1;
    localparam logic [1:0] CMD_RMV  = 2'd2;
    localparam logic [1:0] CMD_EXEC = 2'd3;

    typedef struct packed {
        logic [1:0]           command;
        logic [TASK_ID_W-1:0] task_id;
        logic [USER_W-1:0]    user_id;
        logic [PRIO_W-1:0]    priority_req;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [USER_W-1:0] owner;
    } t_out_item;

endpackage

@@ rtl/core/tpt_ram.sv @@
// ----------------------------------------------------------------------------
// tpt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/task_priority_table_top.sv @@
// ----------------------------------------------------------------------------
// task_priority_table_top
// task table indexed by task id with execute-highest-priority command
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command per
// transfer: add, edit priority, remove, or execute top task. Only execute top
// gives a result on the output channel (o_out_valid / i_out_ready /
// o_out_data): found, and the owner of the executed task (zero if none).
// One command is worked on at a time; o_in_ready is high only when idle.
// Add and remove go through the write state, edit through a read of the valid
// mark, then a write. Execute top: one comparator scans the table, one entry
// per cycle through the ram read port, then the winner's owner is read and
// its valid mark cleared.
// The result sits in an output register; a new command is accepted while it
// waits. A stalled receiver holds the block only when a second result is
// ready to be loaded.
// After reset the valid marks are cleared, one entry per cycle; no command is
// accepted meanwhile.
// ----------------------------------------------------------------------------
module task_priority_table_top #(
    parameter int NUM_TASKS = tpt_pkg::NUM_TASKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tpt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tpt_pkg::t_out_item o_out_data
);

    import tpt_pkg::*;

    localparam int IDX_W = $clog2(NUM_TASKS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_TASKS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_EDIT_RD,
        ST_EDIT_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_LOAD,
        ST_RESULT
    } t_state;

    t_state            r_state,     n_state;
    logic [IDX_W-1:0]  r_cnt,       n_cnt;
    t_in_item          r_item,      n_item;
    logic              r_pend,      n_pend;
    logic [IDX_W-1:0]  r_pend_idx,  n_pend_idx;
    logic              r_have,      n_have;
    logic [IDX_W-1:0]  r_best_idx,  n_best_idx;
    logic [PRIO_W-1:0] r_best_prio, n_best_prio;
    t_out_item         r_res,       n_res;
    logic              r_out_vld,   n_out_vld;
    t_out_item         r_out,       n_out;

    logic              vld_we, usr_we, pri_we;
    logic [IDX_W-1:0]  vld_waddr, vld_raddr, usr_waddr, usr_raddr, pri_waddr, pri_raddr;
    logic              vld_wdata, vld_rdata;
    logic [USER_W-1:0] usr_rdata;
    logic [PRIO_W-1:0] pri_rdata;
    logic [IDX_W-1:0]  item_addr;
    logic              in_range;
    logic              take;

    assign item_addr = IDX_W'(r_item.task_id);
    assign in_range  = (32'(r_item.task_id) < 32'(NUM_TASKS));
    assign take      = vld_rdata && (!r_have || (pri_rdata >= r_best_prio));

    tpt_ram #(.WIDTH(1), .DEPTH(NUM_TASKS)) u_vld_ram (
        .i_clk   (i_clk),
        .i_we    (vld_we),
        .i_waddr (vld_waddr),
        .i_wdata (vld_wdata),
        .i_raddr (vld_raddr),
        .o_rdata (vld_rdata)
    );

    tpt_ram #(.WIDTH(USER_W), .DEPTH(NUM_TASKS)) u_usr_ram (
        .i_clk   (i_clk),
        .i_we    (usr_we),
        .i_waddr (usr_waddr),
        .i_wdata (r_item.user_id),
        .i_raddr (usr_raddr),
        .o_rdata (usr_rdata)
    );

    tpt_ram #(.WIDTH(PRIO_W), .DEPTH(NUM_TASKS)) u_pri_ram (
        .i_clk   (i_clk),
        .i_we    (pri_we),
        .i_waddr (pri_waddr),
        .i_wdata (r_item.priority_req),
        .i_raddr (pri_raddr),
        .o_rdata (pri_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_item      = r_item;
        n_pend      = 1'b0;
        n_pend_idx  = r_cnt;
        n_have      = r_have;
        n_best_idx  = r_best_idx;
        n_best_prio = r_best_prio;
        n_res       = r_res;
        n_out_vld   = r_out_vld;
        n_out       = r_out;

        vld_we    = 1'b0;
        vld_waddr = item_addr;
        vld_wdata = 1'b0;
        vld_raddr = item_addr;
        usr_we    = 1'b0;
        usr_waddr = item_addr;
        usr_raddr = r_best_idx;
        pri_we    = 1'b0;
        pri_waddr = item_addr;
        pri_raddr = item_addr;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        // comparator on the entry read in the previous cycle
        if (r_pend && take) begin
            n_have      = 1'b1;
            n_best_idx  = r_pend_idx;
            n_best_prio = pri_rdata;
        end

        unique case (r_state)
            ST_CLEAR: begin
                vld_we    = 1'b1;
                vld_waddr = r_cnt;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    unique case (i_in_data.command)
                        CMD_ADD:  n_state = ST_WRITE;
                        CMD_RMV:  n_state = ST_WRITE;
                        CMD_EDIT: n_state = ST_EDIT_RD;
                        CMD_EXEC: begin
                            n_state = ST_SCAN;
                            n_cnt   = '0;
                            n_have  = 1'b0;
                        end
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE: begin
                if (in_range) begin
                    vld_we    = 1'b1;
                    vld_wdata = (r_item.command == CMD_ADD);
                    usr_we    = (r_item.command == CMD_ADD);
                    pri_we    = (r_item.command == CMD_ADD);
                end
                n_state = ST_IDLE;
            end
            ST_EDIT_RD: begin
                n_state = ST_EDIT_WR;
            end
            ST_EDIT_WR: begin
                pri_we  = in_range && vld_rdata;
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                vld_raddr  = r_cnt;
                pri_raddr  = r_cnt;
                n_pend     = 1'b1;
                n_pend_idx = r_cnt;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                if (r_have) begin
                    vld_we    = 1'b1;
                    vld_waddr = r_best_idx;
                end
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_res.found = r_have;
                n_res.owner = r_have ? usr_rdata : '0;
                n_state     = ST_RESULT;
            end
            ST_RESULT: begin
                if (!n_out_vld) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_have    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_have      <= n_have;
            r_out_vld   <= n_out_vld;
            r_item      <= n_item;
            r_pend_idx  <= n_pend_idx;
            r_best_idx  <= n_best_idx;
            r_best_prio <= n_best_prio;
            r_res       <= n_res;
            r_out       <= n_out;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/tpt_checker.sv @@
// ----------------------------------------------------------------------------
// tpt_checker
// port level checks on the task priority table, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input tpt_pkg::t_out_item i_out_data
);

    // a waiting result holds until its transfer
    `TPT_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data), "result dropped or changed while stalled")

    // an empty table reports no owner
    `TPT_ASSERT(a_owner_zero, i_out_valid && !i_out_data.found |-> i_out_data.owner == '0, "owner set without a found task")

    // one command at a time
    `TPT_ASSERT(a_busy_after_in, i_in_valid && i_in_ready |=> !i_in_ready, "input accepted while busy")

    // reset clears the result and starts the clearing pass
    `TPT_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !i_in_ready && !i_out_valid, "not quiet after reset")

endmodule

bind task_priority_table_top tpt_checker u_tpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
